FILE: design/fsc_pkg.sv
// Shared types, constants and plane tables for the frustum sphere cull core.
`default_nettype none
package fsc_pkg;
   localparam int PLANE_COUNT_DEF = 6;
   localparam int FRAC_BITS_DEF   = 16;
   localparam int MAT_REGS        = 8;
   localparam int CSR_IDX_W       = 3;
   localparam int ELEM_W          = 32;
   localparam int RAW_W           = 33;
   localparam int SQSUM_W         = 68;
   localparam int ROOT_W          = 34;
   localparam int BASE_PLANES     = 6;

   // Plane construction tables: left, right, bottom, top, near, far.
   localparam logic [BASE_PLANES-1:0] PL_USE3 = 6'b101111;
   localparam logic [BASE_PLANES-1:0] PL_NEG  = 6'b101010;

   function automatic logic [1:0] pl_col(input logic [2:0] p);
      logic [1:0] c;
      case (p)
         3'd0, 3'd1: c = 2'd0;
         3'd2, 3'd3: c = 2'd1;
         3'd4, 3'd5: c = 2'd2;
         default:    c = 2'd0;
      endcase
      return c;
   endfunction

   function automatic logic signed [ELEM_W-1:0] sat32(input logic signed [95:0] v);
      logic signed [ELEM_W-1:0] r;
      if (v > 96'sh7FFFFFFF) r = 32'sh7FFFFFFF;
      else if (v < -96'sh80000000) r = 32'sh80000000;
      else r = v[ELEM_W-1:0];
      return r;
   endfunction

   typedef struct packed {
      logic                     start;
      logic signed [ELEM_W-1:0] cx;
      logic signed [ELEM_W-1:0] cy;
      logic signed [ELEM_W-1:0] cz;
      logic [30:0]              radius;
   } test_cmd_type;
endpackage
`default_nettype wire

FILE: design/fsc_plane_cell.sv
// One plane cell: holds a normalized plane and tests the sphere handed along the row.
`default_nettype none
module fsc_plane_cell import fsc_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     load,
   input  wire logic signed [ELEM_W-1:0] load_nx,
   input  wire logic signed [ELEM_W-1:0] load_ny,
   input  wire logic signed [ELEM_W-1:0] load_nz,
   input  wire logic signed [ELEM_W-1:0] load_off,
   input  wire test_cmd_type             cmd_i,
   input  wire logic                     inside_i,
   output test_cmd_type                  cmd_o,
   output logic                          inside_o
);
   logic signed [ELEM_W-1:0] nx_ff, ny_ff, nz_ff, off_ff;
   test_cmd_type cmd_ff;
   logic inside_ff;
   logic signed [66:0] px, py, pz;
   logic signed [70:0] acc, lim;
   logic pass;

   assign px  = 67'(nx_ff * cmd_i.cx);
   assign py  = 67'(ny_ff * cmd_i.cy);
   assign pz  = 67'(nz_ff * cmd_i.cz);
   assign acc = 71'(px) + 71'(py) + 71'(pz) + (71'(off_ff) <<< FRAC_BITS);
   assign lim = -((71'($signed({1'b0, cmd_i.radius}))) <<< FRAC_BITS);
   assign pass = !(acc < lim);

   always_ff @(posedge clock) begin
      if (load) begin
         nx_ff <= load_nx; ny_ff <= load_ny; nz_ff <= load_nz; off_ff <= load_off;
      end
      cmd_ff    <= cmd_i;
      inside_ff <= inside_i & pass;
      if (reset) cmd_ff.start <= 1'b0;
   end
   assign cmd_o    = cmd_ff;
   assign inside_o = inside_ff;
endmodule
`default_nettype wire

FILE: design/fsc_plane_build.sv
// Plane rebuild sequencer: sums, square root and division, one bit a cycle.
`default_nettype none
module fsc_plane_build import fsc_pkg::*; #(
   parameter int PLANE_COUNT = PLANE_COUNT_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic [MAT_REGS*64-1:0]   mat,
   output logic                          busy,
   output logic                          load_en,
   output logic [$clog2(PLANE_COUNT+1)-1:0] load_idx,
   output logic signed [ELEM_W-1:0]      nx,
   output logic signed [ELEM_W-1:0]      ny,
   output logic signed [ELEM_W-1:0]      nz,
   output logic signed [ELEM_W-1:0]      off
);
   localparam int PW  = $clog2(PLANE_COUNT+1);
   localparam int NUMW = RAW_W + FRAC_BITS;
   localparam int QW  = NUMW;

   typedef enum logic [2:0] {S_IDLE, S_RAW, S_SQ, S_ROOT, S_DIV, S_STORE} state_type;
   state_type state_ff;
   logic [PW-1:0] p_ff;
   logic signed [RAW_W-1:0] a_ff [4];
   logic [1:0] k_ff;
   logic [SQSUM_W-1:0] sum_ff;
   logic [5:0] it_ff;
   logic [ROOT_W+1:0] rem_ff;
   logic [ROOT_W-1:0] root_ff;
   logic [6:0] bit_ff;
   logic [NUMW-1:0] num_ff;
   logic [QW-1:0] q_ff;
   logic [ROOT_W:0] drem_ff;
   logic signed [ELEM_W-1:0] res_ff [4];
   logic load_ff;
   logic [PW-1:0] lidx_ff;

   function automatic logic signed [RAW_W-1:0] el(input logic [MAT_REGS*64-1:0] m,
                                                 input int k);
      return RAW_W'($signed(m[k*32 +: 32]));
   endfunction

   logic signed [RAW_W-1:0] raw [4];
   logic [2:0] pb;
   logic base_ok;
   logic [RAW_W-1:0] mag_k;
   logic [65:0] sq_k;
   logic [ROOT_W+1:0] trial, rem_sh;
   logic [ROOT_W:0] dsh;
   logic [RAW_W-1:0] mag_d;

   always_comb begin
      pb = 3'(p_ff);
      base_ok = (int'(p_ff) < BASE_PLANES);
      for (int i = 0; i < 4; i++) begin
         logic signed [RAW_W-1:0] v, e;
         v = (base_ok && PL_USE3[pb]) ? el(mat, 4*i+3) : '0;
         e = base_ok ? el(mat, 4*i + int'(pl_col(pb))) : '0;
         raw[i] = (base_ok && PL_NEG[pb]) ? v - e : v + e;
      end
      mag_k  = a_ff[k_ff][RAW_W-1] ? RAW_W'(-a_ff[k_ff]) : RAW_W'(a_ff[k_ff]);
      sq_k   = 66'(mag_k) * 66'(mag_k);
      rem_sh = {rem_ff[ROOT_W-1:0], sum_ff[SQSUM_W-1 -: 2]};
      trial  = {root_ff, 2'b01};
      dsh    = {drem_ff[ROOT_W-1:0], num_ff[NUMW-1]};
      mag_d  = a_ff[k_ff][RAW_W-1] ? RAW_W'(-a_ff[k_ff]) : RAW_W'(a_ff[k_ff]);
   end

   always_ff @(posedge clock) begin
      load_ff <= 1'b0;
      case (state_ff)
         S_IDLE: if (start) begin
            p_ff <= '0; state_ff <= S_RAW;
         end
         S_RAW: begin
            for (int i = 0; i < 4; i++) a_ff[i] <= raw[i];
            k_ff <= '0; sum_ff <= '0; state_ff <= S_SQ;
         end
         S_SQ: begin
            sum_ff <= sum_ff + SQSUM_W'(sq_k);
            if (k_ff == 2'd2) begin
               state_ff <= S_ROOT; it_ff <= '0; rem_ff <= '0; root_ff <= '0;
            end
            k_ff <= k_ff + 2'd1;
         end
         S_ROOT: begin
            // one root bit per cycle from the top pair down
            sum_ff <= sum_ff << 2;
            if (rem_sh >= trial) begin
               rem_ff <= rem_sh - trial; root_ff <= {root_ff[ROOT_W-2:0], 1'b1};
            end else begin
               rem_ff <= rem_sh; root_ff <= {root_ff[ROOT_W-2:0], 1'b0};
            end
            it_ff <= it_ff + 6'd1;
            if (it_ff == 6'(ROOT_W-1)) begin
               k_ff <= '0; bit_ff <= '0; state_ff <= S_DIV;
            end
         end
         S_DIV: begin
            if (bit_ff == '0) begin
               num_ff <= NUMW'(mag_d) << FRAC_BITS; drem_ff <= '0; q_ff <= '0;
               bit_ff <= 7'd1;
            end else if (bit_ff <= 7'(NUMW)) begin
               num_ff <= num_ff << 1;
               if (dsh >= {1'b0, root_ff}) begin
                  drem_ff <= dsh - {1'b0, root_ff}; q_ff <= {q_ff[QW-2:0], 1'b1};
               end else begin
                  drem_ff <= dsh; q_ff <= {q_ff[QW-2:0], 1'b0};
               end
               bit_ff <= bit_ff + 7'd1;
            end else begin
               if (root_ff == '0)
                  res_ff[k_ff] <= (k_ff == 2'd3) ? sat32(96'(a_ff[3])) : '0;
               else
                  res_ff[k_ff] <= sat32(a_ff[k_ff][RAW_W-1] ?
                                  -96'($signed({1'b0, q_ff})) : 96'($signed({1'b0, q_ff})));
               bit_ff <= '0;
               if (k_ff == 2'd3) state_ff <= S_STORE;
               k_ff <= k_ff + 2'd1;
            end
         end
         S_STORE: begin
            // latch the slot for the load pulse, then advance to the next plane or, after the last one, go idle
            load_ff <= 1'b1;
            lidx_ff <= p_ff;
            if (p_ff == PW'(PLANE_COUNT-1)) state_ff <= S_IDLE;
            else begin
               p_ff <= p_ff + PW'(1);
               state_ff <= S_RAW;
            end
         end
         default: state_ff <= S_IDLE;
      endcase
      if (reset) begin
         state_ff <= S_IDLE; load_ff <= 1'b0; p_ff <= '0; lidx_ff <= '0;
      end
   end

   assign busy     = (state_ff != S_IDLE) || load_ff;
   assign load_en  = load_ff;
   assign load_idx = lidx_ff;
   assign nx = res_ff[0];
   assign ny = res_ff[1];
   assign nz = res_ff[2];
   assign off = res_ff[3];
endmodule
`default_nettype wire

FILE: design/frustum_sphere_cull_core.sv
// Top level of the frustum sphere cull core.
// Usage: write the matrix over csr_ (index 0..7, two Q16.16 elements each,
// low element in bits 31..0). Any write to index 0..7 marks the planes
// stale; the next sphere on req_ first triggers a rebuild of all planes
// through a shared square root and divider unit, one bit per cycle.
// A sphere then travels down a row of PLANE_COUNT plane cells, one cell a
// cycle, each cell applying one plane test; the result lands in an output
// register and shows on rsp_tdata[0].
// One sphere is in flight at a time.
// When the receiver stalls, the result holds in the output register and
// req_tready stays low until it is taken. Reset clears the matrix, marks
// the planes stale and empties the row.
`default_nettype none
module frustum_sphere_cull_core import fsc_pkg::*; #(
   parameter int PLANE_COUNT = PLANE_COUNT_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   // center_x[31:0], center_y[63:32], center_z[95:64], radius[126:96], zero pad
   input  wire logic [127:0]         req_tdata,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   // inside_res[0], zero pad
   output logic [7:0]                rsp_tdata,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W:0]   csr_index,
   input  wire logic [63:0]          csr_data
);
   localparam int PW = $clog2(PLANE_COUNT+1);

   typedef enum logic [1:0] {T_IDLE, T_BUILD, T_RUN, T_OUT} top_state_type;
   top_state_type state_ff;
   logic [MAT_REGS*64-1:0] mat_ff;
   logic ready_ff, build_go_ff, out_ff;
   test_cmd_type held_ff;
   test_cmd_type cmd [PLANE_COUNT+1];
   logic pass_chain [PLANE_COUNT+1];
   logic busy, load_en;
   logic [PW-1:0] load_idx;
   logic signed [ELEM_W-1:0] bnx, bny, bnz, boff;

   assign req_tready = (state_ff == T_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = (state_ff == T_OUT);
   assign rsp_tdata  = {7'd0, out_ff};

   fsc_plane_build #(.PLANE_COUNT(PLANE_COUNT), .FRAC_BITS(FRAC_BITS)) u_build (
      .clock, .reset, .start(build_go_ff), .mat(mat_ff), .busy, .load_en,
      .load_idx, .nx(bnx), .ny(bny), .nz(bnz), .off(boff)
   );

   assign cmd[0]        = (state_ff == T_RUN && !busy && !build_go_ff) ? held_ff : '0;
   assign pass_chain[0] = 1'b1;

   for (genvar g = 0; g < PLANE_COUNT; g++) begin : g_cell
      fsc_plane_cell #(.FRAC_BITS(FRAC_BITS)) u_cell (
         .clock, .reset, .load(load_en && load_idx == PW'(g)),
         .load_nx(bnx), .load_ny(bny), .load_nz(bnz), .load_off(boff),
         .cmd_i(cmd[g]), .inside_i(pass_chain[g]), .cmd_o(cmd[g+1]),
         .inside_o(pass_chain[g+1])
      );
   end

   always_ff @(posedge clock) begin
      build_go_ff <= 1'b0;
      if (csr_valid && csr_ready && !csr_index[CSR_IDX_W]) begin
         mat_ff[csr_index[CSR_IDX_W-1:0]*64 +: 64] <= csr_data;
         ready_ff <= 1'b0;
      end
      case (state_ff)
         T_IDLE: if (req_tvalid) begin
            held_ff.start  <= 1'b1;
            held_ff.cx     <= req_tdata[31:0];
            held_ff.cy     <= req_tdata[63:32];
            held_ff.cz     <= req_tdata[95:64];
            held_ff.radius <= req_tdata[126:96];
            if (!ready_ff) begin
               build_go_ff <= 1'b1; ready_ff <= 1'b1; state_ff <= T_BUILD;
            end else state_ff <= T_RUN;
         end
         T_BUILD: if (!busy && !build_go_ff) state_ff <= T_RUN;
         T_RUN: begin
            held_ff.start <= 1'b0;
            if (cmd[PLANE_COUNT].start) begin
               out_ff <= pass_chain[PLANE_COUNT]; state_ff <= T_OUT;
            end
         end
         T_OUT: if (rsp_tready) state_ff <= T_IDLE;
         default: state_ff <= T_IDLE;
      endcase
      if (reset) begin
         state_ff <= T_IDLE; mat_ff <= '0; ready_ff <= 1'b0; build_go_ff <= 1'b0;
         held_ff.start <= 1'b0;
      end
   end

   a_one_state: assert property (@(posedge clock) disable iff (reset)
      $onehot({state_ff == T_IDLE, state_ff == T_BUILD, state_ff == T_RUN,
               state_ff == T_OUT})) else $error("state code broken");
   a_no_load_in_run: assert property (@(posedge clock) disable iff (reset)
      state_ff == T_RUN |-> !load_en) else $error("plane load during test");
   a_out_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(out_ff))
      else $error("result lost under stall");
endmodule
`default_nettype wire

FILE: bench/tb.sv
// Self-checking bench for the frustum sphere cull core: matrix phases, sphere stream.
`timescale 1ns / 1ps
module tb;
   import fsc_pkg::*;

   localparam int NUM_PLANES   = PLANE_COUNT_DEF;
   localparam int FRAC         = FRAC_BITS_DEF;
   localparam int IDLE_LIMIT   = 8000;
   localparam int DRAIN_CYCLES = 24;
   localparam int HOLD_CYCLES  = 300;
   localparam logic [31:0] ONE_Q = 32'h0001_0000;

   class cull_scoreboard;
      logic [63:0]        mat [MAT_REGS];
      logic signed [31:0] nrm [3*NUM_PLANES];
      logic signed [31:0] ofs [NUM_PLANES];
      bit                 planes_valid;
      bit                 inside_q [$];
      int                 errors;

      function new();
         foreach (mat[i]) mat[i] = '0;
         planes_valid = 0;
         errors = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W:0] idx, logic [63:0] d);
         if (idx < MAT_REGS) begin
            mat[idx[CSR_IDX_W-1:0]] = d;
            planes_valid = 0;
         end
      endfunction

      function longint element(int k);
         logic [31:0] w;
         w = k[0] ? mat[k >> 1][63:32] : mat[k >> 1][31:0];
         return longint'(signed'(w));
      endfunction

      function logic signed [31:0] clamp32(logic signed [127:0] v);
         if (v > 128'sh7FFFFFFF) return 32'sh7FFFFFFF;
         if (v < -128'sh80000000) return 32'sh80000000;
         return v[31:0];
      endfunction

      function logic [63:0] floor_root(logic [135:0] s);
         logic [135:0] r, t;
         r = '0;
         for (int b = 33; b >= 0; b--) begin
            t = r | (136'd1 << b);
            if (t * t <= s) r = t;
         end
         return r[63:0];
      endfunction

      // signed value scaled by 2^FRAC over the normal length, truncated to zero
      function logic signed [31:0] scale_by_len(longint v, logic [63:0] len);
         logic [127:0] mag, q;
         logic signed [127:0] sv;
         mag = (v < 0) ? 128'(-v) : 128'(v);
         q = (mag << FRAC) / {64'd0, len};
         sv = (v < 0) ? -$signed(q) : $signed(q);
         return clamp32(sv);
      endfunction

      function void rebuild_planes();
         longint       a [4];
         longint       side, e;
         logic [135:0] sq;
         logic [127:0] m;
         logic [63:0]  len;
         int           col;
         for (int p = 0; p < NUM_PLANES; p++) begin
            col = p / 2;
            for (int i = 0; i < 4; i++) begin
               side = PL_USE3[p] ? element(4*i + 3) : 0;
               e = element(4*i + col);
               a[i] = PL_NEG[p] ? side - e : side + e;
            end
            sq = '0;
            for (int i = 0; i < 3; i++) begin
               m = (a[i] < 0) ? 128'(-a[i]) : 128'(a[i]);
               sq += 136'(m) * 136'(m);
            end
            len = floor_root(sq);
            if (len == 0) begin
               for (int i = 0; i < 3; i++) nrm[3*p + i] = '0;
               ofs[p] = clamp32(128'(signed'(a[3])));
            end else begin
               for (int i = 0; i < 3; i++) nrm[3*p + i] = scale_by_len(a[i], len);
               ofs[p] = scale_by_len(a[3], len);
            end
         end
         planes_valid = 1;
      endfunction

      function void note_sphere(logic [127:0] d);
         logic signed [127:0] c [3];
         logic signed [127:0] acc, lim;
         bit                  hit;
         if (!planes_valid) rebuild_planes();
         for (int i = 0; i < 3; i++) c[i] = $signed(d[32*i +: 32]);
         lim = -($signed({97'd0, d[126:96]}) <<< FRAC);
         hit = 1;
         for (int p = 0; p < NUM_PLANES; p++) begin
            acc = (128'(nrm[3*p]) * c[0]) + (128'(nrm[3*p+1]) * c[1])
                + (128'(nrm[3*p+2]) * c[2]) + (128'(ofs[p]) <<< FRAC);
            if (acc < lim) hit = 0;
         end
         inside_q.push_back(hit);
      endfunction

      task report(string msg);
         $display("mismatch @%0t: %s", $realtime, msg);
         errors++;
      endtask

      task check_result(logic [7:0] got);
         bit want;
         if (inside_q.size() == 0) begin
            report($sformatf("unexpected result %0b", got[0]));
            return;
         end
         want = inside_q.pop_front();
         if (got[0] !== want) report($sformatf("inside_res %0b, want %0b", got[0], want));
      endtask
   endclass

   logic                 clock = 0;
   logic                 reset = 1;
   logic                 req_tvalid = 0;
   logic                 req_tready;
   logic [127:0]         req_tdata = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 0;
   logic [7:0]           rsp_tdata;
   logic                 csr_valid = 0;
   logic                 csr_ready;
   logic [CSR_IDX_W:0]   csr_index = '0;
   logic [63:0]          csr_data = '0;

   cull_scoreboard sb = new();
   bit hold_request = 0;
   int idle_cycles = 0;

   frustum_sphere_cull_core DUT (.*);

   always #5 clock = ~clock;

   // result side: random ready, one long hold-off on request
   initial begin
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_tready = 0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 0;
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_tready = ($urandom_range(0, 9) != 0) ? 1'b0 : 1'b1;
         end else begin
            rsp_tready = 1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic write_csr(logic [CSR_IDX_W:0] idx, logic [63:0] d);
      csr_index = idx;
      csr_data = d;
      csr_valid = 1;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, d);
      @(negedge clock);
      csr_valid = 0;
   endtask

   task automatic send_sphere(logic [127:0] d);
      int gap;
      req_tdata = d;
      req_tvalid = 1;
      do @(posedge clock); while (!req_tready);
      sb.note_sphere(d);
      @(negedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid = 0;
         repeat (gap) @(negedge clock);
      end
   endtask

   function automatic logic [127:0] pack_sphere(logic [31:0] x, logic [31:0] y,
                                                logic [31:0] z, logic [30:0] r);
      return {1'b0, r, z, y, x};
   endfunction

   function automatic logic [31:0] rand_coord();
      int r;
      r = $urandom_range(0, 9);
      if (r < 7) return 32'($signed($urandom_range(0, 2**20)) - 2**19);
      return $urandom();
   endfunction

   function automatic logic [30:0] rand_radius();
      int r;
      r = $urandom_range(0, 9);
      if (r < 2) return '0;
      if (r < 7) return 31'($urandom_range(0, 2**17));
      return 31'($urandom());
   endfunction

   function automatic logic [31:0] rand_element();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return $urandom();
      if (r == 1) return '0;
      return 32'($signed($urandom_range(0, 2**19)) - 2**18);
   endfunction

   // wait out everything in flight before touching the matrix
   task automatic drain();
      req_tvalid = 0;
      while (sb.inside_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic load_matrix(logic [31:0] e [16]);
      for (int n = 0; n < MAT_REGS; n++)
         write_csr((CSR_IDX_W+1)'(n), {e[2*n+1], e[2*n]});
   endtask

   initial begin
      logic [31:0] m [16];
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // reset matrix: every plane degenerate
      send_sphere(pack_sphere(32'h7FFFFFFF, 32'h80000000, 32'h0, 31'h0));
      drain();

      foreach (m[k]) m[k] = '0;
      m[0] = ONE_Q; m[5] = ONE_Q; m[10] = ONE_Q; m[15] = ONE_Q;
      load_matrix(m);
      send_sphere(pack_sphere('0, '0, '0, '0));
      send_sphere(pack_sphere(ONE_Q, '0, 32'h0000_8000, '0));
      send_sphere(pack_sphere(32'h0002_0000, '0, 32'h0000_8000, '0));
      send_sphere(pack_sphere(32'h0002_0000, '0, 32'h0000_8000, 31'h0001_0000));
      send_sphere(pack_sphere(32'h0002_0000, '0, 32'h0000_8000, 31'h0000_FFFF));
      send_sphere(pack_sphere('0, 32'hFFFE_0000, 32'h0000_8000, '0));
      send_sphere(pack_sphere('0, '0, 32'hFFFF_0000, '0));
      send_sphere(pack_sphere('0, '0, 32'h0002_0000, '0));
      send_sphere(pack_sphere(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 31'h7FFFFFFF));
      send_sphere(pack_sphere(32'h80000000, 32'h80000000, 32'h80000000, 31'h7FFFFFFF));
      send_sphere(pack_sphere(32'h80000000, 32'h7FFFFFFF, 32'h80000000, '0));
      send_sphere(pack_sphere(32'hFFFFFFFF, 32'h1, 32'h1, 31'h1));
      drain();

      // out-of-range index: planes keep their contents
      write_csr(4'd8, '1);
      write_csr(4'd15, '1);
      send_sphere(pack_sphere('0, '0, 32'h0000_8000, '0));
      drain();

      // extreme matrices: all elements at either limit, largest normal lengths
      foreach (m[k]) m[k] = 32'h7FFFFFFF;
      load_matrix(m);
      for (int i = 0; i < 4; i++) send_sphere(pack_sphere($urandom(), $urandom(), $urandom(), 31'($urandom())));
      drain();
      foreach (m[k]) m[k] = 32'h80000000;
      load_matrix(m);
      for (int i = 0; i < 4; i++) send_sphere(pack_sphere($urandom(), $urandom(), $urandom(), 31'($urandom())));
      drain();

      for (int phase = 0; phase < 8; phase++) begin
         foreach (m[k]) m[k] = rand_element();
         // keep a usable frustum shape most of the time
         if (phase % 3 != 2) begin
            m[0] = ONE_Q + m[0][15:0]; m[5] = ONE_Q + m[5][15:0];
            m[10] = ONE_Q; m[15] = ONE_Q;
         end
         if (phase == 0) load_matrix(m);
         else begin
            for (int n = 0; n < MAT_REGS; n++)
               if ($urandom_range(0, 3) != 0)
                  write_csr((CSR_IDX_W+1)'(n), {m[2*n+1], m[2*n]});
            if ($urandom_range(0, 1)) write_csr(4'(MAT_REGS + $urandom_range(0, 7)), $urandom());
         end
         for (int i = 0; i < 215; i++) begin
            if (phase == 3 && i == 20) hold_request = 1;
            send_sphere(pack_sphere(rand_coord(), rand_coord(), rand_coord(), rand_radius()));
         end
         drain();
      end

      if (sb.errors == 0) $display("tb OK");
      else $display("tb NOT OK");
      $finish;
   end
endmodule
